FILE: hw/rtl/refcounted_node_pool_defines.svh
// ----------------------------------------------------------------------------
// Refcounted node pool assertion macros
// Shared concurrent assertion wrappers; the using scope provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_NODE_POOL_DEFINES_SVH
`define REFCOUNTED_NODE_POOL_DEFINES_SVH

// Checked outside reset only.
`define RNP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define RNP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rnp_pkg.sv
// ----------------------------------------------------------------------------
// Refcounted node pool package
// Shared constants, transaction types and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rnp_pkg;

  localparam int IDX_W          = 8;
  localparam int CNT_W          = 8;
  localparam int POOL_SLOTS_DEF = 128;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_LINK   = 2'd2,
    MODE_UNLINK = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t            mode;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic             fault;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_AL_SCAN,
    ST_FR_SCAN,
    ST_FR_CNT,
    ST_LK_RD,
    ST_LK_DEC,
    ST_LK_INC,
    ST_UL_RD,
    ST_UL_DEC,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rnp_ram.sv
// ----------------------------------------------------------------------------
// Refcounted node pool RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rnp_ram #(
  parameter int   DEPTH = rnp_pkg::POOL_SLOTS_DEF,
  parameter int   WIDTH = rnp_pkg::IDX_W,
  localparam int  AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rnp_engine.sv
// ----------------------------------------------------------------------------
// Refcounted node pool engine
// Sequencer over the count and link memories: clear, allocate, free, link,
// unlink by read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

`include "refcounted_node_pool_defines.svh"

module rnp_engine #(
  parameter int POOL_SLOTS = rnp_pkg::POOL_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rnp_pkg::req_t req,
  output logic          done_valid,
  input  logic          done_take,
  output rnp_pkg::rsp_t result
);

  localparam int AW = $clog2(POOL_SLOTS);
  localparam logic [rnp_pkg::IDX_W-1:0] NONE = rnp_pkg::IDX_W'(POOL_SLOTS);
  localparam logic [AW-1:0] LAST = AW'(POOL_SLOTS - 1);

  rnp_pkg::state_t state, state_next;
  logic [AW-1:0]               scan;
  logic [rnp_pkg::CNT_W-1:0]   dec;
  logic [rnp_pkg::IDX_W-1:0]   old_tgt;
  rnp_pkg::mode_t              op;
  logic [rnp_pkg::IDX_W-1:0]   a_idx;
  logic [rnp_pkg::IDX_W-1:0]   b_idx;
  rnp_pkg::rsp_t               res;

  logic [rnp_pkg::IDX_W-1:0]   in_a;
  logic [rnp_pkg::IDX_W-1:0]   in_b;

  logic                        cnt_we;
  logic [AW-1:0]               cnt_waddr;
  logic [rnp_pkg::CNT_W-1:0]   cnt_wdata;
  logic [AW-1:0]               cnt_raddr;
  logic [rnp_pkg::CNT_W-1:0]   cnt_rdata;
  logic                        lnk_we;
  logic [AW-1:0]               lnk_waddr;
  logic [rnp_pkg::IDX_W-1:0]   lnk_wdata;
  logic [AW-1:0]               lnk_raddr;
  logic [rnp_pkg::IDX_W-1:0]   lnk_rdata;

  assign in_a   = (req.first_index >= NONE) ? NONE : req.first_index;
  assign in_b   = (req.second_index >= NONE) ? NONE : req.second_index;
  assign result = res;

  rnp_ram #(.DEPTH(POOL_SLOTS), .WIDTH(rnp_pkg::CNT_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  rnp_ram #(.DEPTH(POOL_SLOTS), .WIDTH(rnp_pkg::IDX_W)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (lnk_raddr),
    .rdata (lnk_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rnp_pkg::ST_CLEAR: begin
        if (scan == LAST) state_next = rnp_pkg::ST_IDLE;
      end
      rnp_pkg::ST_IDLE: begin
        if (req_valid) begin
          unique case (req.mode)
            rnp_pkg::MODE_ALLOC:  state_next = rnp_pkg::ST_AL_SCAN;
            rnp_pkg::MODE_FREE:
              state_next = (in_a == NONE) ? rnp_pkg::ST_DONE : rnp_pkg::ST_FR_SCAN;
            rnp_pkg::MODE_LINK:
              state_next = (in_a == NONE) ? rnp_pkg::ST_DONE : rnp_pkg::ST_LK_RD;
            rnp_pkg::MODE_UNLINK:
              state_next = (in_a == NONE) ? rnp_pkg::ST_DONE : rnp_pkg::ST_UL_RD;
          endcase
        end
      end
      rnp_pkg::ST_AL_SCAN: begin
        if (cnt_rdata == '0 || scan == LAST) state_next = rnp_pkg::ST_DONE;
      end
      rnp_pkg::ST_FR_SCAN: begin
        if (scan == LAST) state_next = rnp_pkg::ST_FR_CNT;
      end
      rnp_pkg::ST_FR_CNT: state_next = rnp_pkg::ST_DONE;
      rnp_pkg::ST_LK_RD: begin
        state_next = (lnk_rdata == b_idx) ? rnp_pkg::ST_DONE : rnp_pkg::ST_LK_DEC;
      end
      rnp_pkg::ST_LK_DEC: state_next = rnp_pkg::ST_LK_INC;
      rnp_pkg::ST_LK_INC: state_next = rnp_pkg::ST_DONE;
      rnp_pkg::ST_UL_RD: begin
        state_next = (lnk_rdata == NONE) ? rnp_pkg::ST_DONE : rnp_pkg::ST_UL_DEC;
      end
      rnp_pkg::ST_UL_DEC: state_next = rnp_pkg::ST_DONE;
      rnp_pkg::ST_DONE: begin
        if (done_take) state_next = rnp_pkg::ST_IDLE;
      end
      default: state_next = rnp_pkg::ST_IDLE;
    endcase
  end

  // memory controls and handshake
  always_comb begin
    req_ready  = 1'b0;
    done_valid = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = scan;
    cnt_wdata  = '0;
    cnt_raddr  = AW'(scan + 1'b1);
    lnk_we     = 1'b0;
    lnk_waddr  = scan;
    lnk_wdata  = NONE;
    lnk_raddr  = AW'(scan + 1'b1);
    unique case (state)
      rnp_pkg::ST_CLEAR: begin
        cnt_we = 1'b1;
        lnk_we = 1'b1;
      end
      rnp_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        cnt_raddr = '0;
        lnk_raddr = (req.mode == rnp_pkg::MODE_FREE) ? '0 : in_a[AW-1:0];
      end
      rnp_pkg::ST_AL_SCAN: begin
        if (cnt_rdata == '0) begin
          cnt_we    = 1'b1;
          cnt_wdata = rnp_pkg::CNT_W'(1);
        end
      end
      rnp_pkg::ST_FR_SCAN: begin
        cnt_raddr = a_idx[AW-1:0];
        if (lnk_rdata == a_idx) lnk_we = 1'b1;
      end
      rnp_pkg::ST_FR_CNT: begin
        cnt_we    = 1'b1;
        cnt_waddr = a_idx[AW-1:0];
      end
      rnp_pkg::ST_LK_RD: begin
        cnt_raddr = lnk_rdata[AW-1:0];
        lnk_waddr = a_idx[AW-1:0];
        lnk_wdata = b_idx;
        if (lnk_rdata != b_idx) lnk_we = 1'b1;
      end
      rnp_pkg::ST_LK_DEC: begin
        cnt_raddr = b_idx[AW-1:0];
        cnt_waddr = old_tgt[AW-1:0];
        cnt_wdata = cnt_rdata - 1'b1;
        if (old_tgt != NONE) cnt_we = 1'b1;
      end
      rnp_pkg::ST_LK_INC: begin
        cnt_waddr = b_idx[AW-1:0];
        cnt_wdata = cnt_rdata + 1'b1;
        if (b_idx != NONE) cnt_we = 1'b1;
      end
      rnp_pkg::ST_UL_RD: begin
        cnt_raddr = lnk_rdata[AW-1:0];
        lnk_waddr = a_idx[AW-1:0];
        if (lnk_rdata != NONE) lnk_we = 1'b1;
      end
      rnp_pkg::ST_UL_DEC: begin
        cnt_we    = 1'b1;
        cnt_waddr = old_tgt[AW-1:0];
        cnt_wdata = cnt_rdata - 1'b1;
      end
      rnp_pkg::ST_DONE: done_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rnp_pkg::ST_CLEAR;
      scan  <= '0;
    end else begin
      state <= state_next;
      priority case (state)
        rnp_pkg::ST_CLEAR, rnp_pkg::ST_AL_SCAN, rnp_pkg::ST_FR_SCAN:
          scan <= AW'(scan + 1'b1);
        rnp_pkg::ST_IDLE: scan <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    priority case (state)
      rnp_pkg::ST_IDLE: begin
        if (req_valid) begin
          op               <= req.mode;
          a_idx            <= in_a;
          b_idx            <= in_b;
          dec              <= '0;
          res.result_index <= NONE;
          res.fault        <= 1'b0;
        end
      end
      rnp_pkg::ST_AL_SCAN: begin
        if (cnt_rdata == '0) res.result_index <= rnp_pkg::IDX_W'(scan);
      end
      rnp_pkg::ST_FR_SCAN: begin
        if (lnk_rdata == a_idx) dec <= dec + 1'b1;
      end
      rnp_pkg::ST_FR_CNT: res.fault <= ((cnt_rdata - dec) != rnp_pkg::CNT_W'(1));
      rnp_pkg::ST_LK_RD, rnp_pkg::ST_UL_RD: old_tgt <= lnk_rdata;
      rnp_pkg::ST_UL_DEC: res.result_index <= old_tgt;
      default: ;
    endcase
  end

  `RNP_ASSERT_ALWAYS(a_rst_blocks_req, rst |=> !req_ready, "request taken right after reset")
  `RNP_ASSERT(a_busy_while_done, done_valid |-> !req_ready, "request taken with result pending")
  `RNP_ASSERT(a_idle_after_take, done_valid && done_take |=> req_ready, "not idle after result")
  `RNP_ASSERT(a_index_range, done_valid |-> result.result_index <= NONE, "result index range")
  `RNP_ASSERT(a_fault_on_free, done_valid && result.fault |-> op == rnp_pkg::MODE_FREE,
              "fault outside free")

endmodule

`default_nettype wire

FILE: hw/rtl/refcounted_node_pool.sv
// ----------------------------------------------------------------------------
// Refcounted node pool
// Fixed pool of list nodes with reference counts and one link per node.
// ----------------------------------------------------------------------------
// After reset the block sweeps both memories, clearing every slot, and takes
// no transaction until that is done. Transactions are then served one at a
// time by a sequencer around a count memory and a link memory, each with one
// write and one registered read port. Allocate reads counts one slot per
// cycle until it finds a slot with a zero count or reaches the end of the
// pool; free scans every link; a free, link or unlink of none touches no
// memory. The result sits in an output register, so the next transaction is
// accepted while it waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module refcounted_node_pool #(
  parameter int POOL_SLOTS = rnp_pkg::POOL_SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  rnp_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output rnp_pkg::rsp_t rsp
);

  logic          done_valid;
  logic          done_take;
  rnp_pkg::rsp_t done_result;

  assign done_take = !rsp_valid || rsp_ready;

  rnp_engine #(.POOL_SLOTS(POOL_SLOTS)) u_engine (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .done_valid (done_valid),
    .done_take  (done_take),
    .result     (done_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done_take) begin
      rsp_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_take) begin
      rsp <= done_result;
    end
  end

endmodule

`default_nettype wire
